/* hdl/ksod_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ksod_pkg
// Shared constants, codes and control types of the keyspace odometer.
// ----------------------------------------------------------------------------
package ksod_pkg;

  // fixed field widths
  localparam int POS_W      = 53;
  localparam int ODW        = 7;
  localparam int OUT_DIGITS = 8;

  // configuration port
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 7;

  // register indexes
  localparam logic [CFG_IW-1:0] REG_LAST  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_FIXED = 2'd1;
  localparam logic [CFG_IW-1:0] REG_TOP   = 2'd2;

  // item commands
  localparam logic CMD_STEP = 1'b0;
  localparam logic CMD_SEEK = 1'b1;

  // shared divider: dividend and divisor widths
  localparam int DIV_W = 64;
  localparam int DVS_W = 9;

  // controller states
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DIV1   = 6'b000010,
    S_SHIFT  = 6'b000100,
    S_HORN   = 6'b001000,
    S_LAUNCH = 6'b010000,
    S_DIV2   = 6'b100000
  } ksod_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic seek_load;
    logic step;
    logic div1_next;
    logic shift;
    logic horner;
    logic div2_start;
    logic div2_next;
  } ksod_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_done;
    logic idx_zero;
    logic horn_last;
    logic f_zero;
    logic c_zero;
    logic out_full;
  } ksod_stat_t;

endpackage
`default_nettype wire

/* hdl/ksod_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ksod_if
// Item and result channels of the keyspace odometer, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ksod_item_if;
  import ksod_pkg::*;
  logic             valid;
  logic             ready;
  logic             command;
  logic [POS_W-1:0] position;

  modport source (output valid, command, position, input ready);
  modport sink (input valid, command, position, output ready);
endinterface

interface ksod_result_if;
  import ksod_pkg::*;
  logic           valid;
  logic           ready;
  logic [ODW-1:0] digit_0;
  logic [ODW-1:0] digit_1;
  logic [ODW-1:0] digit_2;
  logic [ODW-1:0] digit_3;
  logic [ODW-1:0] digit_4;
  logic [ODW-1:0] digit_5;
  logic [ODW-1:0] digit_6;
  logic [ODW-1:0] digit_7;
  logic           done_res;

  modport source (output valid, digit_0, digit_1, digit_2, digit_3, digit_4, digit_5,
                  digit_6, digit_7, done_res, input ready);
  modport sink (input valid, digit_0, digit_1, digit_2, digit_3, digit_4, digit_5,
                digit_6, digit_7, done_res, output ready);
endinterface
`default_nettype wire

/* hdl/ksod_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ksod_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ksod_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ksod_pkg::DIV_W-1:0] dividend,
  input  logic [ksod_pkg::DVS_W-1:0] divisor,
  output logic                       busy,
  output logic                       done,
  output logic [ksod_pkg::DIV_W-1:0] quotient,
  output logic [ksod_pkg::DVS_W-1:0] remainder
);
  import ksod_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic [CW-1:0]    count;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   trial;
  logic             take;

  // trial subtract of the next partial remainder
  always_comb begin
    trial = {remainder, quotient[DIV_W-1]};
    take  = (trial >= {1'b0, dvs});
  end

  // shift register holds dividend, then quotient
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (count == '0);
      if (start) begin
        quotient  <= dividend;
        remainder <= '0;
        dvs       <= divisor;
        count     <= CW'(DIV_W - 1);
        busy      <= 1'b1;
      end else if (busy) begin
        quotient  <= {quotient[DIV_W-2:0], take};
        remainder <= take ? DVS_W'(trial - {1'b0, dvs}) : DVS_W'(trial);
        count     <= count - CW'(1);
        if (count == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider not busy after start");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");

endmodule
`default_nettype wire

/* hdl/ksod_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ksod_ctrl
// Sequencer: steps taken directly in the idle state, multi-phase seek conversion.
// ----------------------------------------------------------------------------
module ksod_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic                 item_command,
  output logic                 item_ready,
  input  ksod_pkg::ksod_stat_t stat,
  output ksod_pkg::ksod_cmd_t  cmd
);
  import ksod_pkg::*;

  ksod_state_t state;
  ksod_state_t state_next;

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    item_ready = (state == S_IDLE) && !stat.out_full;
    unique case (state)
      S_IDLE: begin
        if (item_valid && item_ready) begin
          if (item_command == CMD_SEEK) begin
            cmd.seek_load = 1'b1;
            state_next    = S_DIV1;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      S_DIV1: begin
        if (stat.div_done) begin
          cmd.div1_next = 1'b1;
          if (stat.idx_zero) begin
            state_next = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        cmd.shift  = 1'b1;
        state_next = (stat.f_zero || stat.c_zero) ? S_IDLE : S_HORN;
      end
      S_HORN: begin
        cmd.horner = 1'b1;
        if (stat.horn_last) begin
          state_next = S_LAUNCH;
        end
      end
      S_LAUNCH: begin
        cmd.div2_start = 1'b1;
        state_next     = S_DIV2;
      end
      S_DIV2: begin
        if (stat.div_done) begin
          cmd.div2_next = 1'b1;
          if (stat.idx_zero) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_seek_entry: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV1 && $past(state) == S_IDLE) |-> $past(item_valid && item_command == CMD_SEEK))
    else $error("seek phase entered without a seek transfer");
  a_done_phase: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> (state == S_DIV1 || state == S_DIV2))
    else $error("divider finished outside a divide phase");

endmodule
`default_nettype wire

/* hdl/ksod_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ksod_datapath
// Config registers, digit store, odometer increment, seek conversion, output
// register.
// ----------------------------------------------------------------------------
module ksod_datapath #(
  parameter int MAX_DIGITS   = 8,
  parameter int CHARSET_SIZE = 95
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           cfg_we,
  input  logic [ksod_pkg::CFG_IW-1:0]                    cfg_index,
  input  logic [ksod_pkg::CFG_DW-1:0]                    cfg_data,
  input  logic [ksod_pkg::POS_W-1:0]                     position,
  input  ksod_pkg::ksod_cmd_t                            cmd,
  output ksod_pkg::ksod_stat_t                           stat,
  input  logic                                           out_ready,
  output logic                                           out_valid,
  output logic [ksod_pkg::OUT_DIGITS-1:0][ksod_pkg::ODW-1:0] out_digit,
  output logic                                           out_done
);
  import ksod_pkg::*;

  localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int DW = $clog2(CHARSET_SIZE);
  localparam logic [IW-1:0] IDX_ONE = IW'(1);
  localparam logic [DW:0]   INC_ONE = {{DW{1'b0}}, 1'b1};

  // configuration registers
  logic [2:0] last_position;
  logic [2:0] fixed_position;
  logic [6:0] top_index;

  // saturated settings
  logic [IW-1:0] eff_last;
  logic [IW-1:0] eff_fixed;
  logic [DW-1:0] eff_top;
  logic [DW:0]   base;

  // digit store and seek working state
  logic [DW-1:0]    digits [MAX_DIGITS];
  logic             finished;
  logic [IW-1:0]    idx;
  logic [DIV_W-1:0] value;
  logic [DIV_W-1:0] horner_next;

  // odometer increment
  logic [MAX_DIGITS-1:0] prop;
  logic [MAX_DIGITS-1:0] carry_in;
  logic [DW-1:0]         inc_digit [MAX_DIGITS];
  logic [DW-1:0]         step_digit [MAX_DIGITS];
  logic                  step_done;
  logic [OUT_DIGITS-1:0][ODW-1:0] show;

  // divider hookup
  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic             div_busy;
  logic             div_done;
  logic [DIV_W-1:0] div_quot;
  logic [DVS_W-1:0] div_rem;

  // saturate registers
  always_comb begin
    if (int'(last_position) > MAX_DIGITS - 1) begin
      eff_last = IW'(MAX_DIGITS - 1);
    end else begin
      eff_last = IW'(last_position);
    end
    if (int'(fixed_position) > int'(eff_last)) begin
      eff_fixed = eff_last;
    end else begin
      eff_fixed = IW'(fixed_position);
    end
    if (int'(top_index) > CHARSET_SIZE - 1) begin
      eff_top = DW'(CHARSET_SIZE - 1);
    end else begin
      eff_top = DW'(top_index);
    end
    base = {1'b0, eff_top} + INC_ONE;
  end

  // per-digit wrap flags and carry prefix, last digit fastest
  always_comb begin
    logic [DW:0] inc;
    for (int p = 0; p < MAX_DIGITS; p++) begin
      inc = {1'b0, digits[p]} + INC_ONE;
      if (p > int'(eff_last) || p == int'(eff_fixed)) begin
        prop[p] = 1'b1;
      end else if (p > int'(eff_fixed)) begin
        prop[p] = (inc > {1'b0, eff_top});
      end else begin
        prop[p] = (inc >= {1'b0, eff_top});
      end
      inc_digit[p] = DW'(inc);
    end
    carry_in[MAX_DIGITS-1] = 1'b1;
    for (int p = MAX_DIGITS - 2; p >= 0; p--) begin
      carry_in[p] = carry_in[p+1] & prop[p+1];
    end
    step_done = carry_in[0] & prop[0];
    for (int p = 0; p < MAX_DIGITS; p++) begin
      if (p == int'(eff_fixed)) begin
        step_digit[p] = eff_top;
      end else if (p <= int'(eff_last) && carry_in[p]) begin
        step_digit[p] = prop[p] ? '0 : inc_digit[p];
      end else begin
        step_digit[p] = digits[p];
      end
    end
  end

  // candidate shown on a step, fixed slot pinned, zero past the last digit
  for (genvar j = 0; j < OUT_DIGITS; j++) begin : g_show
    if (j < MAX_DIGITS) begin : g_live
      assign show[j] = (j > int'(eff_last)) ? '0 :
                       (j == int'(eff_fixed)) ? ODW'(eff_top) : ODW'(digits[j]);
    end else begin : g_pad
      assign show[j] = '0;
    end
  end

  // horner accumulate, wraps at the divider width
  assign horner_next = DIV_W'(value * base) + DIV_W'(digits[idx]);

  // divider operand select
  always_comb begin
    div_start = cmd.seek_load || cmd.div2_start ||
                ((cmd.div1_next || cmd.div2_next) && (idx != '0));
    if (cmd.seek_load) begin
      div_dividend = DIV_W'(position);
    end else if (cmd.div2_start) begin
      div_dividend = value;
    end else begin
      div_dividend = div_quot;
    end
    if (cmd.div2_start || cmd.div2_next) begin
      div_divisor = DVS_W'(eff_top);
    end else begin
      div_divisor = DVS_W'(base);
    end
  end

  ksod_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // status to the controller
  always_comb begin
    stat.div_done  = div_done;
    stat.idx_zero  = (idx == '0);
    stat.horn_last = (({1'b0, idx} + {1'b0, IDX_ONE}) == {1'b0, eff_fixed});
    stat.f_zero    = (eff_fixed == '0);
    stat.c_zero    = (eff_top == '0);
    stat.out_full  = out_valid && !out_ready;
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      last_position  <= 3'd7;
      fixed_position <= 3'd0;
      top_index      <= 7'd94;
      for (int p = 0; p < MAX_DIGITS; p++) begin
        digits[p] <= '0;
      end
      finished  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // config write
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LAST:  last_position  <= cfg_data[2:0];
          REG_FIXED: fixed_position <= cfg_data[2:0];
          REG_TOP:   top_index      <= cfg_data[6:0];
          default: ;
        endcase
      end

      // step: emit candidate and advance, else clear on result transfer
      if (cmd.step && !finished) begin
        out_valid <= 1'b1;
        out_digit <= show;
        out_done  <= step_done;
        finished  <= step_done;
        for (int p = 0; p < MAX_DIGITS; p++) begin
          digits[p] <= step_digit[p];
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // seek start
      if (cmd.seek_load) begin
        for (int p = 0; p < MAX_DIGITS; p++) begin
          digits[p] <= '0;
        end
        idx      <= eff_last;
        finished <= 1'b0;
      end

      // base top+1 digit, lowest digit rounded away unless it is the fixed slot
      if (cmd.div1_next) begin
        if (idx == eff_last && eff_fixed != eff_last) begin
          digits[idx] <= '0;
        end else begin
          digits[idx] <= DW'(div_rem);
        end
        if (idx != '0) begin
          idx <= idx - IDX_ONE;
        end
      end

      // move digits past the fixed slot
      if (cmd.shift) begin
        for (int p = 0; p < MAX_DIGITS - 1; p++) begin
          if (p < int'(eff_fixed)) begin
            digits[p] <= digits[p+1];
          end
        end
        digits[eff_fixed] <= eff_top;
        value <= '0;
        idx   <= '0;
      end

      // rebuild the value of the digits below the fixed slot
      if (cmd.horner) begin
        value <= horner_next;
        idx   <= idx + IDX_ONE;
      end

      // re-express in base top
      if (cmd.div2_start) begin
        idx <= eff_fixed - IDX_ONE;
      end
      if (cmd.div2_next) begin
        digits[idx] <= DW'(div_rem);
        if (idx != '0) begin
          idx <= idx - IDX_ONE;
        end
      end
    end
  end

  a_seek_div: assert property (@(posedge clk) disable iff (rst) cmd.seek_load |=> div_busy)
    else $error("seek did not launch the divider");

endmodule
`default_nettype wire

/* hdl/keyspace_odometer_with_seek_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyspace_odometer_with_seek_top
// Mixed-radix candidate enumerator with seek to a position.
// ----------------------------------------------------------------------------
// channel   dir  handshake      payload
// item      in   valid/ready    command, position
// result    out  valid/ready    digit_0..digit_7, done_res
// cfg       in   cfg_we         cfg_index, cfg_data
//
// A step is taken from idle; with the result side ready and no seek in progress,
// one candidate per cycle. A seek runs the shared bit-serial divider, 64 quotient
// bits, once per digit: L+1 digits in base top+1, then, unless F or top is zero,
// a Horner pass and F digits in base top (L last digit, F fixed slot).
// Reset is synchronous; digit store, done flag and output valid clear at once.
// A waiting result holds off the item channel; a step is taken in the cycle the
// waiting result transfers.
// ----------------------------------------------------------------------------
module keyspace_odometer_with_seek_top #(
  parameter int MAX_DIGITS   = 8,
  parameter int CHARSET_SIZE = 95
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [ksod_pkg::CFG_IW-1:0] cfg_index,
  input  logic [ksod_pkg::CFG_DW-1:0] cfg_data,
  ksod_item_if.sink                   item,
  ksod_result_if.source               result
);
  import ksod_pkg::*;

  ksod_cmd_t                      cmd;
  ksod_stat_t                     stat;
  logic [OUT_DIGITS-1:0][ODW-1:0] out_digit;

  ksod_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_command (item.command),
    .item_ready   (item.ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  ksod_datapath #(
    .MAX_DIGITS   (MAX_DIGITS),
    .CHARSET_SIZE (CHARSET_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .position  (item.position),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .out_digit (out_digit),
    .out_done  (result.done_res)
  );

  // result payload
  assign result.digit_0 = out_digit[0];
  assign result.digit_1 = out_digit[1];
  assign result.digit_2 = out_digit[2];
  assign result.digit_3 = out_digit[3];
  assign result.digit_4 = out_digit[4];
  assign result.digit_5 = out_digit[5];
  assign result.digit_6 = out_digit[6];
  assign result.digit_7 = out_digit[7];

endmodule
`default_nettype wire
